>>> hw/rtl/tcc_pkg.sv
package tcc_pkg;

   localparam int NUM_LANES   = 9;
   localparam int NUM_SLOTS   = 12;
   localparam int DIV_STEPS   = 9;    // three quotient bits per step
   localparam int RADIX_BITS  = 3;
   localparam int QW          = DIV_STEPS * RADIX_BITS;

   localparam logic [1:0] REG_PARALLEL_TOL = 2'd0;
   localparam logic [1:0] REG_INSIDE_TOL   = 2'd1;

   localparam logic [3:0] CASE_NONE     = 4'd0;
   localparam logic [3:0] CASE_C1I2SAME = 4'd1;
   localparam logic [3:0] CASE_C1I2DIF  = 4'd2;
   localparam logic [3:0] CASE_C2I2SAME = 4'd3;
   localparam logic [3:0] CASE_C2I2DIF  = 4'd4;
   localparam logic [3:0] CASE_I4SAME   = 4'd5;
   localparam logic [3:0] CASE_I4DIF    = 4'd6;
   localparam logic [3:0] CASE_C1I4SAME = 4'd7;
   localparam logic [3:0] CASE_C1I4DIF  = 4'd8;
   localparam logic [3:0] CASE_I2       = 4'd9;
   localparam logic [3:0] CASE_C3       = 4'd10;
   localparam logic [3:0] CASE_UNKNOWN  = 4'd11;

   localparam logic [1:0] CLIP_BOTTOM = 2'd0;   // y = 0
   localparam logic [1:0] CLIP_DIAG   = 2'd1;   // x + y = 1
   localparam logic [1:0] CLIP_LEFT   = 2'd2;   // x = 0

   localparam logic signed [26:0] ONE_Q16 = 27'sd65536;

   typedef struct packed {
      logic signed [23:0] vertex0_xi;
      logic signed [23:0] vertex0_eta;
      logic signed [23:0] vertex1_xi;
      logic signed [23:0] vertex1_eta;
      logic signed [23:0] vertex2_xi;
      logic signed [23:0] vertex2_eta;
   } req_type;

   typedef struct packed {
      logic               point_valid;
      logic               is_corner;
      logic [1:0]         clip_edge;
      logic [1:0]         source_edge;
      logic signed [23:0] point_xi;
      logic signed [23:0] point_eta;
      logic [3:0]         case_code;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic init;
      logic step;
      logic fin;
   } lane_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   // True when the point lies inside all three reference edges.
   function automatic logic inside_test(input logic signed [23:0] x,
                                        input logic signed [23:0] y,
                                        input logic [20:0] itol);
      logic signed [26:0] xe;
      logic signed [26:0] ye;
      logic signed [26:0] tol;
      logic signed [26:0] dot_b;
      logic signed [26:0] dot_d;
      logic signed [26:0] dot_l;
      xe    = {{3{x[23]}}, x};
      ye    = {{3{y[23]}}, y};
      tol   = {6'd0, itol};
      dot_b = -ye;
      dot_d = xe + ye - ONE_Q16;
      dot_l = -xe;
      return !(dot_b > tol) && !(dot_d > tol) && !(dot_l > tol);
   endfunction

endpackage

>>> hw/rtl/tcc_lane.sv
module tcc_lane import tcc_pkg::*; (
   input  logic               clock,
   input  lane_ctrl_type      ctrl,
   input  logic [1:0]         clip,
   input  logic signed [23:0] p0_x,
   input  logic signed [23:0] p0_y,
   input  logic signed [23:0] p1_x,
   input  logic signed [23:0] p1_y,
   input  logic [20:0]        ptol,
   input  logic [20:0]        itol,
   output logic               hit,
   output logic signed [23:0] pt_x,
   output logic signed [23:0] pt_y
);

   logic signed [23:0] p0x_ff, p0y_ff;
   logic signed [25:0] dx_ff, dy_ff;
   logic signed [26:0] den_ff, num_ff;
   logic signed [52:0] prx_ff, pry_ff;
   logic               ok_ff, negx_ff, negy_ff;
   logic [27:0]        dsr_ff;
   logic [27:0]        remx_ff, remy_ff;
   logic [QW-1:0]      qx_ff, qy_ff;
   logic               hit_ff;
   logic signed [23:0] ptx_ff, pty_ff;

   logic signed [25:0] dx_in, dy_in;
   logic signed [26:0] den_in, num_in, dxe, dye;
   logic signed [52:0] prx_in, pry_in;
   logic [26:0]        aden;
   logic               ok_in;
   logic [52:0]        apx, apy;
   logic [53:0]        nx, ny;
   logic [27:0]        remx_in, remy_in;
   logic [QW-1:0]      qx_in, qy_in;
   logic signed [26:0] sx, sy;
   logic signed [23:0] fx, fy;

   // edge setup
   always_comb begin
      dx_in = {{2{p1_x[23]}}, p1_x} - {{2{p0_x[23]}}, p0_x};
      dy_in = {{2{p1_y[23]}}, p1_y} - {{2{p0_y[23]}}, p0_y};
      dxe   = {dx_in[25], dx_in};
      dye   = {dy_in[25], dy_in};
      case (clip)
         CLIP_BOTTOM: begin
            den_in = dye;
            num_in = -{{3{p0_y[23]}}, p0_y};
         end
         CLIP_DIAG: begin
            den_in = -(dxe + dye);
            num_in = {{3{p0_x[23]}}, p0_x} + {{3{p0_y[23]}}, p0_y} - ONE_Q16;
         end
         default: begin
            den_in = dxe;
            num_in = -{{3{p0_x[23]}}, p0_x};
         end
      endcase
   end

   // parallel and alpha range tests, products
   always_comb begin
      aden   = den_ff[26] ? 27'(-den_ff) : 27'(den_ff);
      ok_in  = (den_ff != '0) && !(aden < {6'd0, ptol});
      if (!den_ff[26])
         ok_in = ok_in && !num_ff[26] && !(num_ff > den_ff);
      else
         ok_in = ok_in && !(num_ff > 0) && !(num_ff < den_ff);
      prx_in = num_ff * dx_ff;
      pry_in = num_ff * dy_ff;
   end

   // rounding divide: floor((2|p| + |q|) / (2|q|))
   always_comb begin
      apx = prx_ff[52] ? 53'(-prx_ff) : 53'(prx_ff);
      apy = pry_ff[52] ? 53'(-pry_ff) : 53'(pry_ff);
      nx  = {apx, 1'b0} + {27'd0, aden};
      ny  = {apy, 1'b0} + {27'd0, aden};
   end

   always_comb begin
      logic [28:0] tx, ty;
      remx_in = remx_ff;
      remy_in = remy_ff;
      qx_in   = qx_ff;
      qy_in   = qy_ff;
      tx      = '0;
      ty      = '0;
      for (int b = 0; b < RADIX_BITS; b++) begin
         tx = {remx_in, qx_in[QW-1]};
         ty = {remy_in, qy_in[QW-1]};
         if (tx >= {1'b0, dsr_ff}) tx = tx - {1'b0, dsr_ff};
         else                      tx[0] = tx[0];
         qx_in   = {qx_in[QW-2:0], ({remx_in, qx_in[QW-1]} >= {1'b0, dsr_ff})};
         qy_in   = {qy_in[QW-2:0], ({remy_in, qy_in[QW-1]} >= {1'b0, dsr_ff})};
         if (ty >= {1'b0, dsr_ff}) ty = ty - {1'b0, dsr_ff};
         remx_in = tx[27:0];
         remy_in = ty[27:0];
      end
   end

   always_comb begin
      sx = {{3{p0x_ff[23]}}, p0x_ff} + (negx_ff ? -$signed(qx_ff) : $signed(qx_ff));
      sy = {{3{p0y_ff[23]}}, p0y_ff} + (negy_ff ? -$signed(qy_ff) : $signed(qy_ff));
      fx = sx[23:0];
      fy = sy[23:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         p0x_ff <= p0_x;
         p0y_ff <= p0_y;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         den_ff <= den_in;
         num_ff <= num_in;
      end
      if (ctrl.mul) begin
         ok_ff   <= ok_in;
         prx_ff  <= prx_in;
         pry_ff  <= pry_in;
         negx_ff <= prx_in[52] ^ den_ff[26];
         negy_ff <= pry_in[52] ^ den_ff[26];
      end
      if (ctrl.init) begin
         dsr_ff  <= {aden, 1'b0};
         remx_ff <= {1'b0, nx[53:QW]};
         remy_ff <= {1'b0, ny[53:QW]};
         qx_ff   <= nx[QW-1:0];
         qy_ff   <= ny[QW-1:0];
      end
      if (ctrl.step) begin
         remx_ff <= remx_in;
         remy_ff <= remy_in;
         qx_ff   <= qx_in;
         qy_ff   <= qy_in;
      end
      if (ctrl.fin) begin
         hit_ff <= ok_ff && inside_test(fx, fy, itol);
         ptx_ff <= fx;
         pty_ff <= fy;
      end
   end

   assign hit  = hit_ff;
   assign pt_x = ptx_ff;
   assign pt_y = pty_ff;

endmodule

>>> hw/rtl/tcc_merge.sv
module tcc_merge import tcc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   take,
   input  logic [NUM_LANES-1:0]   lane_hit,
   input  logic signed [23:0]     lane_x [NUM_LANES],
   input  logic signed [23:0]     lane_y [NUM_LANES],
   input  req_type                vtx,
   input  logic [20:0]            itol,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data
);

   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic                 empty_ff, empty_in;
   logic [3:0]           code_ff;
   logic signed [23:0]   sx_ff [NUM_SLOTS];
   logic signed [23:0]   sy_ff [NUM_SLOTS];
   logic                 rv_ff, rv_in;
   rsp_type              rd_ff, rd_in;

   logic [NUM_SLOTS-1:0] hits;
   logic signed [23:0]   cx [3];
   logic signed [23:0]   cy [3];
   logic [3:0]           ninter;
   logic [1:0]           ncorner;
   logic [1:0]           npair;
   logic [1:0]           pc;
   logic [3:0]           code_in;
   logic [3:0]           sel;
   logic [1:0]           sel_clip;
   logic [1:0]           sel_src;
   logic [NUM_SLOTS-1:0] rest;
   logic                 adv;

   always_comb begin
      cx[0] = vtx.vertex0_xi;  cy[0] = vtx.vertex0_eta;
      cx[1] = vtx.vertex1_xi;  cy[1] = vtx.vertex1_eta;
      cx[2] = vtx.vertex2_xi;  cy[2] = vtx.vertex2_eta;
      hits[NUM_LANES-1:0] = lane_hit;
      for (int i = 0; i < 3; i++)
         hits[NUM_LANES+i] = inside_test(cx[i], cy[i], itol);
      ninter  = '0;
      ncorner = '0;
      npair   = '0;
      for (int k = 0; k < NUM_LANES; k++)
         ninter = ninter + 4'(lane_hit[k]);
      for (int i = 0; i < 3; i++)
         ncorner = ncorner + 2'(hits[NUM_LANES+i]);
      for (int c = 0; c < 3; c++) begin
         pc = 2'(lane_hit[3*c]) + 2'(lane_hit[3*c+1]) + 2'(lane_hit[3*c+2]);
         if (pc == 2'd2) npair = npair + 2'd1;
      end
      if (ncorner == 2'd1 && ninter == 4'd2)
         code_in = (npair != 0) ? CASE_C1I2SAME : CASE_C1I2DIF;
      else if (ncorner == 2'd2 && ninter == 4'd2)
         code_in = (npair != 0) ? CASE_C2I2SAME : CASE_C2I2DIF;
      else if (ncorner == 2'd0 && ninter == 4'd4)
         code_in = (npair == 2'd2) ? CASE_I4SAME :
                   (npair == 2'd1) ? CASE_I4DIF : CASE_UNKNOWN;
      else if (ncorner == 2'd1 && ninter == 4'd4)
         code_in = (npair == 2'd2) ? CASE_C1I4SAME :
                   (npair == 2'd1) ? CASE_C1I4DIF : CASE_UNKNOWN;
      else if (ncorner == 2'd0 && ninter == 4'd2)
         code_in = (npair == 2'd0) ? CASE_I2 : CASE_UNKNOWN;
      else if (ncorner == 2'd3 && ninter == 4'd0)
         code_in = CASE_C3;
      else
         code_in = CASE_UNKNOWN;
   end

   assign free = (mask_ff == '0) && !empty_ff;
   assign adv  = !rv_ff || rsp_ready;

   // lowest pending slot goes out next; slot = 3 * reference edge + triangle edge,
   // corners after the nine intersection slots
   always_comb begin
      sel = '0;
      for (int k = NUM_SLOTS - 1; k >= 0; k--)
         if (mask_ff[k]) sel = 4'(k);
      rest = mask_ff & ~(NUM_SLOTS'(1) << sel);
      if (sel >= 4'(NUM_LANES)) begin
         sel_clip = 2'd0;
         sel_src  = 2'(sel - 4'(NUM_LANES));
      end else if (sel >= 4'd6) begin
         sel_clip = CLIP_LEFT;
         sel_src  = 2'(sel - 4'd6);
      end else if (sel >= 4'd3) begin
         sel_clip = CLIP_DIAG;
         sel_src  = 2'(sel - 4'd3);
      end else begin
         sel_clip = CLIP_BOTTOM;
         sel_src  = sel[1:0];
      end
   end

   always_comb begin
      mask_in  = mask_ff;
      empty_in = empty_ff;
      rv_in    = rv_ff;
      rd_in    = rd_ff;
      if (adv) begin
         rv_in = 1'b0;
         if (mask_ff != '0) begin
            rv_in             = 1'b1;
            rd_in.point_valid = 1'b1;
            rd_in.is_corner   = (sel >= 4'(NUM_LANES));
            rd_in.clip_edge   = sel_clip;
            rd_in.source_edge = sel_src;
            rd_in.point_xi    = sx_ff[sel];
            rd_in.point_eta   = sy_ff[sel];
            rd_in.case_code   = code_ff;
            rd_in.last        = (rest == '0);
            mask_in           = rest;
         end else if (empty_ff) begin
            rv_in    = 1'b1;
            rd_in    = '0;
            rd_in.case_code = CASE_NONE;
            rd_in.last      = 1'b1;
            empty_in = 1'b0;
         end
      end
      if (take) begin
         mask_in  = hits;
         empty_in = (hits == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         empty_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         empty_ff <= empty_in;
         rv_ff    <= rv_in;
      end
      rd_ff <= rd_in;
      if (take) begin
         code_ff <= code_in;
         for (int k = 0; k < NUM_LANES; k++) begin
            sx_ff[k] <= lane_x[k];
            sy_ff[k] <= lane_y[k];
         end
         for (int i = 0; i < 3; i++) begin
            sx_ff[NUM_LANES+i] <= cx[i];
            sy_ff[NUM_LANES+i] <= cy[i];
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rd_ff;

endmodule

>>> hw/rtl/triangle_clip_classifier_top.sv
// Triangle clip classifier. A triangle in reference-triangle coordinates
// (signed Q8.16) arrives as one req_ transfer; every edge is clipped against
// the three reference edge lines in nine parallel lanes, corners are tested
// at the merge, and the surviving points leave one rsp_ transfer per cycle
// while rsp_ready is high, intersections first (by reference edge, then
// triangle edge), then corners, all tagged with one case code, last set on
// the final point. With no overlap a single marker with point_valid 0 is
// sent. The lanes' rounding divider retires three quotient bits of a 27-bit
// quotient per cycle after a multiply step and a divider setup step, then a
// finish step registers the point; the output side runs concurrently with
// the lanes working on the next triangle. Registers are written on csr_we:
// index 0 parallel tolerance, index 1 inside tolerance.
module triangle_clip_classifier_top import tcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [20:0] csr_wdata
);

   logic [20:0]   ptol_ff, itol_ff;
   state_type     state_ff, state_in;
   logic [3:0]    cnt_ff, cnt_in;
   req_type       vtx_ff;

   logic          accept, take, merge_free;
   lane_ctrl_type ctrl;

   logic signed [23:0]   vx [3];
   logic signed [23:0]   vy [3];
   logic [NUM_LANES-1:0] lane_hit;
   logic signed [23:0]   lane_x [NUM_LANES];
   logic signed [23:0]   lane_y [NUM_LANES];

   // config registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         ptol_ff <= 21'd1;
         itol_ff <= 21'd0;
      end else if (csr_we) begin
         if (csr_index == REG_PARALLEL_TOL) ptol_ff <= csr_wdata;
         if (csr_index == REG_INSIDE_TOL)   itol_ff <= csr_wdata;
      end
   end

   // hand results to the merge stage while loading the next triangle
   assign take      = (state_ff == ST_HOLD) && merge_free;
   assign req_ready = (state_ff == ST_IDLE) || take;
   assign accept    = req_valid && req_ready;

   // lane schedule: cnt 0 multiply, 1 divider setup, 2..10 divide, 11 finish
   assign ctrl.load = accept;
   assign ctrl.mul  = (state_ff == ST_RUN) && (cnt_ff == 4'd0);
   assign ctrl.init = (state_ff == ST_RUN) && (cnt_ff == 4'd1);
   assign ctrl.step = (state_ff == ST_RUN) && (cnt_ff >= 4'd2) && (cnt_ff <= 4'd10);
   assign ctrl.fin  = (state_ff == ST_RUN) && (cnt_ff == 4'd11);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: ;
         ST_RUN: begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd11) state_in = ST_HOLD;
         end
         ST_HOLD: if (take) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (accept) begin
         state_in = ST_RUN;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      if (accept) vtx_ff <= req_data;
   end

   always_comb begin
      vx[0] = req_data.vertex0_xi;  vy[0] = req_data.vertex0_eta;
      vx[1] = req_data.vertex1_xi;  vy[1] = req_data.vertex1_eta;
      vx[2] = req_data.vertex2_xi;  vy[2] = req_data.vertex2_eta;
   end

   // lane index = 3 * reference edge + triangle edge
   for (genvar c = 0; c < 3; c++) begin : g_clip
      for (genvar m = 0; m < 3; m++) begin : g_edge
         tcc_lane u_lane (
            .clock (clock),
            .ctrl  (ctrl),
            .clip  (2'(c)),
            .p0_x  (vx[m]),
            .p0_y  (vy[m]),
            .p1_x  (vx[(m + 1) % 3]),
            .p1_y  (vy[(m + 1) % 3]),
            .ptol  (ptol_ff),
            .itol  (itol_ff),
            .hit   (lane_hit[3*c+m]),
            .pt_x  (lane_x[3*c+m]),
            .pt_y  (lane_y[3*c+m])
         );
      end
   end

   tcc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .lane_hit  (lane_hit),
      .lane_x    (lane_x),
      .lane_y    (lane_y),
      .vtx       (vtx_ff),
      .itol      (itol_ff),
      .free      (merge_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (cnt_ff == 4'd0))
      else $error("accepted triangle did not start lane run");

   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      ctrl.fin && !accept |=> (state_ff == ST_HOLD))
      else $error("lane results not held after finish");

   a_take_frees: assert property (@(posedge clock) disable iff (reset)
      take |=> !merge_free || (rsp_valid && rsp_data.last && !rsp_data.point_valid) ||
               rsp_valid)
      else $error("merge stage loaded without producing output");

endmodule
